// ----- sv/cdn_pkg.sv -----
// ----------------------------------------------------------------------------
// cdn_pkg
// Shared types, constants and calendar helper functions.
// ----------------------------------------------------------------------------
package cdn_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD       = 2'd0,
        CMD_NEXT_DAY   = 2'd1,
        CMD_NEXT_MONTH = 2'd2,
        CMD_PREV_MONTH = 2'd3
    } cmd_t;

    localparam logic [13:0] MIN_YEAR   = 14'd1;
    localparam logic [13:0] MAX_YEAR   = 14'd9999;
    localparam logic [3:0]  JAN        = 4'd1;
    localparam logic [3:0]  FEB        = 4'd2;
    localparam logic [3:0]  DEC        = 4'd12;
    localparam logic [8:0]  LAST_YMOD  = 9'd399;
    // floor(x / 400) == (x * RECIP_400) >> 22 for x < 10000
    localparam logic [13:0] RECIP_400  = 14'd10486;
    localparam logic [13:0] YEARS_400  = 14'd400;

    localparam logic [13:0] RST_YEAR   = 14'd2026;
    localparam logic [3:0]  RST_MONTH  = 4'd2;
    localparam logic [4:0]  RST_DAY    = 5'd20;
    localparam logic [2:0]  RST_FW     = 3'd6;
    localparam logic [4:0]  RST_LEN    = 5'd28;
    localparam logic [8:0]  RST_YMOD   = 9'd26;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } pipe_en_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [8:0]  ymod;
        logic [2:0]  fw;
        logic [4:0]  len;
    } load_word_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  fw;
        logic [4:0]  len;
    } cal_state_t;

    function automatic logic [2:0] mod7(input logic [8:0] a);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = 5'(a[8:6]) + 5'(a[5:3]) + 5'(a[2:0]);
        s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
        if (s2 >= 4'd7)
            return 3'(s2 - 4'd7);
        return 3'(s2);
    endfunction

    // ymod is year % 400
    function automatic logic leap_of(input logic [8:0] ymod);
        return (ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200)
               && (ymod != 9'd300);
    endfunction

    function automatic logic [4:0] len_of(input logic leap, input logic [3:0] m);
        logic [4:0] n;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            4'd2:                    n = leap ? 5'd29 : 5'd28;
            default:                 n = 5'd31;
        endcase
        return n;
    endfunction

    // days before the first of month m, mod 7, common year
    function automatic logic [2:0] month_off(input logic [3:0] m);
        logic [2:0] o;
        case (m)
            4'd1:    o = 3'd0;
            4'd2:    o = 3'd3;
            4'd3:    o = 3'd3;
            4'd4:    o = 3'd6;
            4'd5:    o = 3'd1;
            4'd6:    o = 3'd4;
            4'd7:    o = 3'd6;
            4'd8:    o = 3'd2;
            4'd9:    o = 3'd5;
            4'd10:   o = 3'd0;
            4'd11:   o = 3'd3;
            default: o = 3'd5;
        endcase
        return o;
    endfunction

    function automatic logic [2:0] row_of(input logic [5:0] p);
        logic [2:0] r;
        if (p < 6'd7)       r = 3'd0;
        else if (p < 6'd14) r = 3'd1;
        else if (p < 6'd21) r = 3'd2;
        else if (p < 6'd28) r = 3'd3;
        else if (p < 6'd35) r = 3'd4;
        else                r = 3'd5;
        return r;
    endfunction

endpackage

// ----- sv/calendar_date_navigator.sv -----
// ----------------------------------------------------------------------------
// calendar_date_navigator
// Throughput: one word per cycle; three prep stages and the date update
// stage each hold one word, and a stalled result only blocks once all fill.
// Reset: pipeline empty, date set to 2026-02-20 (first weekday Sunday).
// ----------------------------------------------------------------------------
module calendar_date_navigator
    import cdn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  cmd,
    input  logic [13:0] load_year,
    input  logic [3:0]  load_month,
    input  logic [4:0]  load_day,

    output logic        res_valid,
    input  logic        res_stall,
    output logic [13:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  days_in_month,
    output logic [2:0]  first_weekday,
    output logic [2:0]  grid_row,
    output logic [2:0]  grid_col,
    output logic        day_valid
);

    logic       v1_reg, v2_reg, v3_reg, ov_reg;
    logic       en_out;
    pipe_en_t   en;
    logic       upd;
    load_word_t word;
    cal_state_t st;
    logic       dv;
    logic [5:0] p;
    logic [2:0] row;

    always_comb
    begin
        en_out = !ov_reg || !res_stall;
        en.s3  = !v3_reg || en_out;
        en.s2  = !v2_reg || en.s3;
        en.s1  = !v1_reg || en.s2;
        upd    = en_out && v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
                v1_reg <= cmd_valid;
            if (en.s2)
                v2_reg <= v1_reg;
            if (en.s3)
                v3_reg <= v2_reg;
            if (en_out)
                ov_reg <= v3_reg;
        end
    end

    cdn_load_prep u_prep (
        .clk        (clk),
        .en         (en),
        .cmd        (cmd),
        .load_year  (load_year),
        .load_month (load_month),
        .load_day   (load_day),
        .word       (word)
    );

    cdn_nav u_nav (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .word  (word),
        .st    (st)
    );

    // grid cell of the held date
    always_comb
    begin
        dv  = (st.day != 5'd0) && (st.day <= st.len);
        p   = 6'(st.fw) + 6'(st.day) - 6'd1;
        row = row_of(p);
    end

    assign cmd_stall     = !en.s1;
    assign res_valid     = ov_reg;
    assign year          = st.year;
    assign month         = st.month;
    assign day           = st.day;
    assign days_in_month = st.len;
    assign first_weekday = st.fw;
    assign day_valid     = dv;
    assign grid_row      = dv ? row : 3'd0;
    assign grid_col      = dv ? 3'(p - ({row, 3'b000} - 6'(row))) : 3'd0;

endmodule

// ----- sv/cdn_load_prep.sv -----
// ----------------------------------------------------------------------------
// cdn_load_prep
// Three-stage front end: clamps the load year and month, derives year % 400,
// the weekday of the first and the month length for the load command.
// ----------------------------------------------------------------------------
module cdn_load_prep
    import cdn_pkg::*;
(
    input  logic        clk,
    input  pipe_en_t    en,
    input  logic [1:0]  cmd,
    input  logic [13:0] load_year,
    input  logic [3:0]  load_month,
    input  logic [4:0]  load_day,
    output load_word_t  word
);

    logic [13:0] y_clamp;
    logic [3:0]  m_clamp;
    logic [26:0] prod;

    cmd_t        s1_cmd_reg;
    logic [13:0] s1_year_reg;
    logic [3:0]  s1_month_reg;
    logic [4:0]  s1_day_reg;
    logic [4:0]  s1_q_reg;

    logic [13:0] s2_q400;
    logic [8:0]  s2_r_next;

    cmd_t        s2_cmd_reg;
    logic [13:0] s2_year_reg;
    logic [3:0]  s2_month_reg;
    logic [4:0]  s2_day_reg;
    logic [8:0]  s2_r_reg;

    logic [8:0]  s3_ymod;
    logic        s3_leap;
    logic [1:0]  s3_hund;
    logic [8:0]  s3_sum;
    logic [2:0]  s3_jan1;
    load_word_t  word_next;
    load_word_t  word_reg;

    // stage 1: clamp, reciprocal multiply for (year - 1) / 400
    always_comb
    begin
        if (load_year == 14'd0)
            y_clamp = MIN_YEAR;
        else if (load_year > MAX_YEAR)
            y_clamp = MAX_YEAR;
        else
            y_clamp = load_year;

        if (load_month == 4'd0)
            m_clamp = JAN;
        else if (load_month > DEC)
            m_clamp = DEC;
        else
            m_clamp = load_month;

        prod = 27'(y_clamp - 14'd1) * 27'(RECIP_400);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            s1_cmd_reg   <= cmd_t'(cmd);
            s1_year_reg  <= y_clamp;
            s1_month_reg <= m_clamp;
            s1_day_reg   <= load_day;
            s1_q_reg     <= prod[26:22];
        end
    end

    // stage 2: remainder (year - 1) % 400
    always_comb
    begin
        s2_q400   = 14'(s1_q_reg) * YEARS_400;
        s2_r_next = 9'(s1_year_reg - 14'd1 - s2_q400);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            s2_cmd_reg   <= s1_cmd_reg;
            s2_year_reg  <= s1_year_reg;
            s2_month_reg <= s1_month_reg;
            s2_day_reg   <= s1_day_reg;
            s2_r_reg     <= s2_r_next;
        end
    end

    // stage 3: weekday of Jan 1 from (year - 1) % 400, then month offset
    always_comb
    begin
        s3_ymod = (s2_r_reg == LAST_YMOD) ? 9'd0 : s2_r_reg + 9'd1;
        s3_leap = leap_of(s3_ymod);
        if (s2_r_reg >= 9'd300)
            s3_hund = 2'd3;
        else if (s2_r_reg >= 9'd200)
            s3_hund = 2'd2;
        else if (s2_r_reg >= 9'd100)
            s3_hund = 2'd1;
        else
            s3_hund = 2'd0;
        s3_sum  = s2_r_reg + 9'(s2_r_reg[8:2]) - 9'(s3_hund);
        s3_jan1 = mod7(s3_sum);

        word_next.cmd   = s2_cmd_reg;
        word_next.year  = s2_year_reg;
        word_next.month = s2_month_reg;
        word_next.day   = s2_day_reg;
        word_next.ymod  = s3_ymod;
        word_next.fw    = mod7(9'(s3_jan1) + 9'(month_off(s2_month_reg))
                               + 9'(s3_leap && (s2_month_reg > FEB)));
        word_next.len   = len_of(s3_leap, s2_month_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
            word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ----- sv/cdn_nav.sv -----
// ----------------------------------------------------------------------------
// cdn_nav
// Current date state and the single-pass update for all four commands.
// ----------------------------------------------------------------------------
module cdn_nav
    import cdn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       upd,
    input  load_word_t word,
    output cal_state_t st
);

    logic [13:0] year_reg,  year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg,   day_next;
    logic [2:0]  fw_reg,    fw_next;
    logic [4:0]  len_reg,   len_next;
    logic [8:0]  ymod_reg,  ymod_next;

    logic        leap_c;
    logic [8:0]  ymod_inc;
    logic [8:0]  ymod_dec;
    logic        day_ok;
    logic [5:0]  p;
    logic [2:0]  fw_fwd;

    logic [3:0]  nm_month;
    logic [13:0] nm_year;
    logic [8:0]  nm_ymod;
    logic [4:0]  nm_len;
    logic        nm_block;
    logic [5:0]  nm_off;
    logic [4:0]  nm_day;

    logic [3:0]  pm_month;
    logic [13:0] pm_year;
    logic [8:0]  pm_ymod;
    logic [4:0]  pm_len;
    logic [2:0]  pm_fw;
    logic        pm_block;
    logic [5:0]  pm_fw6;
    logic [5:0]  pm_last;
    logic [2:0]  pm_row;
    logic [5:0]  pm_rbase;
    logic [5:0]  pm_ubase;
    logic [5:0]  pm_start;
    logic [4:0]  pm_day;

    always_comb
    begin
        leap_c   = leap_of(ymod_reg);
        ymod_inc = (ymod_reg == LAST_YMOD) ? 9'd0 : ymod_reg + 9'd1;
        ymod_dec = (ymod_reg == 9'd0) ? LAST_YMOD : ymod_reg - 9'd1;
        day_ok   = (day_reg != 5'd0) && (day_reg <= len_reg);
        p        = 6'(fw_reg) + 6'(day_reg) - 6'd1;
        fw_fwd   = mod7(9'(fw_reg) + 9'(len_reg));

        // next month target
        nm_month = (month_reg == DEC) ? JAN : month_reg + 4'd1;
        nm_year  = (month_reg == DEC) ? year_reg + 14'd1 : year_reg;
        nm_ymod  = (month_reg == DEC) ? ymod_inc : ymod_reg;
        nm_len   = len_of(leap_c, nm_month);
        nm_block = (month_reg == DEC) && (year_reg >= MAX_YEAR);
        nm_off   = p - 6'(fw_fwd);
        if (p < 6'(fw_fwd))
            nm_day = 5'd1;
        else if (nm_off >= 6'(nm_len))
            nm_day = nm_len;
        else
            nm_day = 5'(nm_off + 6'd1);

        // previous month target
        pm_month = (month_reg == JAN) ? DEC : month_reg - 4'd1;
        pm_year  = (month_reg == JAN) ? year_reg - 14'd1 : year_reg;
        pm_ymod  = (month_reg == JAN) ? ymod_dec : ymod_reg;
        pm_len   = len_of(leap_c, pm_month);
        pm_block = (month_reg == JAN) && (year_reg <= MIN_YEAR);
        pm_fw    = mod7(9'(fw_reg) + 9'(6'd35 - 6'(pm_len)));
        pm_fw6   = 6'(pm_fw);
        pm_last  = pm_fw6 + 6'(pm_len) - 6'd1;
        pm_row   = row_of(p);
        pm_rbase = {pm_row, 3'b000} - 6'(pm_row);
        pm_ubase = pm_rbase - 6'd7;
        pm_start = (pm_ubase >= pm_fw6) ? pm_ubase : pm_fw6;
        if (p >= pm_fw6 && p <= pm_last)
            pm_day = 5'(p - pm_fw6 + 6'd1);
        else if (p < pm_fw6)
            pm_day = pm_len;
        else if (pm_last >= pm_rbase)
            pm_day = pm_len;
        else if (pm_row != 3'd0 && pm_start <= pm_last)
            pm_day = 5'(pm_start - pm_fw6 + 6'd1);
        else
            pm_day = pm_len;

        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        fw_next    = fw_reg;
        len_next   = len_reg;
        ymod_next  = ymod_reg;

        if (upd)
        begin
            unique case (word.cmd)
                CMD_LOAD:
                begin
                    year_next  = word.year;
                    month_next = word.month;
                    day_next   = word.day;
                    fw_next    = word.fw;
                    len_next   = word.len;
                    ymod_next  = word.ymod;
                end
                CMD_NEXT_DAY:
                begin
                    if (day_reg == len_reg)
                    begin
                        if (!nm_block)
                        begin
                            year_next  = nm_year;
                            month_next = nm_month;
                            day_next   = 5'd1;
                            fw_next    = fw_fwd;
                            len_next   = nm_len;
                            ymod_next  = nm_ymod;
                        end
                    end
                    else
                    begin
                        day_next = day_reg + 5'd1;
                    end
                end
                CMD_NEXT_MONTH:
                begin
                    if (day_ok && !nm_block)
                    begin
                        year_next  = nm_year;
                        month_next = nm_month;
                        day_next   = nm_day;
                        fw_next    = fw_fwd;
                        len_next   = nm_len;
                        ymod_next  = nm_ymod;
                    end
                end
                CMD_PREV_MONTH:
                begin
                    if (day_ok && !pm_block)
                    begin
                        year_next  = pm_year;
                        month_next = pm_month;
                        day_next   = pm_day;
                        fw_next    = pm_fw;
                        len_next   = pm_len;
                        ymod_next  = pm_ymod;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg  <= RST_YEAR;
            month_reg <= RST_MONTH;
            day_reg   <= RST_DAY;
            fw_reg    <= RST_FW;
            len_reg   <= RST_LEN;
            ymod_reg  <= RST_YMOD;
        end
        else
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            fw_reg    <= fw_next;
            len_reg   <= len_next;
            ymod_reg  <= ymod_next;
        end
    end

    assign st.year  = year_reg;
    assign st.month = month_reg;
    assign st.day   = day_reg;
    assign st.fw    = fw_reg;
    assign st.len   = len_reg;

    a_hold_without_update: assert property (@(posedge clk) disable iff (!rst_n)
        !upd |=> $stable(year_reg) && $stable(month_reg) && $stable(day_reg)
                 && $stable(fw_reg) && $stable(len_reg) && $stable(ymod_reg))
        else $error("date state changed without an update");

    a_len_matches_month: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg == len_of(leap_of(ymod_reg), month_reg))
        else $error("month length out of step with month and year");

    a_month_move_invalid_day: assert property (@(posedge clk) disable iff (!rst_n)
        upd && (word.cmd == CMD_NEXT_MONTH || word.cmd == CMD_PREV_MONTH) && !day_ok
        |=> $stable(year_reg) && $stable(month_reg) && $stable(day_reg))
        else $error("month move on invalid day changed the date");

    a_next_day_carry: assert property (@(posedge clk) disable iff (!rst_n)
        upd && word.cmd == CMD_NEXT_DAY && day_reg == len_reg && month_reg != DEC
        |=> day_reg == 5'd1 && month_reg == $past(month_reg) + 4'd1)
        else $error("next day month carry wrong");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for calendar_date_navigator. A directed table covers
// reset state, year and field extremes, invalid days and the month-move
// edge rules. A random mix of loads and navigation commands follows. Every
// result word is checked field by field against a table row or an in-bench
// calendar model. Both sides idle at random; one long result hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_top
    import cdn_pkg::*;
();

    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 750;
    localparam int DIR_ROWS     = 25;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  len;
        logic [2:0]  fw;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        valid;
    } cal_result_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [13:0] ly;
        logic [3:0]  lm;
        logic [4:0]  ld;
        logic        typed;
        cal_result_t res;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    cmd_t        cmd;
    logic [13:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
    logic        res_valid;
    logic        res_stall;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  days_in_month;
    logic [2:0]  first_weekday;
    logic [2:0]  grid_row;
    logic [2:0]  grid_col;
    logic        day_valid;

    cal_result_t expected_dates [$];
    int          errors        = 0;
    int          words_sent    = 0;
    int          dates_checked = 0;
    int          cmd_counts [4] = '{0, 0, 0, 0};
    int          cycle_count   = 0;
    int          hold_requests = 0;
    bit          no_idle       = 1'b0;

    // calendar model state
    int cal_y   = 2026;
    int cal_m   = 2;
    int cal_d   = 20;
    int cal_fw  = 6;
    int cal_len = 28;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{CMD_NEXT_DAY,   14'h3FFF, 4'hF,  5'h1F, 1'b1,
          '{14'd2026, 4'd2,  5'd21, 5'd28, 3'd6, 3'd3, 3'd5, 1'b1}},
        '{CMD_LOAD,       14'd9999, 4'd12, 5'd31, 1'b1,
          '{14'd9999, 4'd12, 5'd31, 5'd31, 3'd2, 3'd4, 3'd4, 1'b1}},
        '{CMD_NEXT_DAY,   14'd0,    4'd0,  5'd0,  1'b1,
          '{14'd9999, 4'd12, 5'd31, 5'd31, 3'd2, 3'd4, 3'd4, 1'b1}},
        '{CMD_NEXT_MONTH, 14'd0,    4'd0,  5'd0,  1'b1,
          '{14'd9999, 4'd12, 5'd31, 5'd31, 3'd2, 3'd4, 3'd4, 1'b1}},
        '{CMD_LOAD,       14'd0,    4'd0,  5'd1,  1'b1,
          '{14'd1,    4'd1,  5'd1,  5'd31, 3'd0, 3'd0, 3'd0, 1'b1}},
        '{CMD_PREV_MONTH, 14'h3FFF, 4'hF,  5'h1F, 1'b1,
          '{14'd1,    4'd1,  5'd1,  5'd31, 3'd0, 3'd0, 3'd0, 1'b1}},
        '{CMD_LOAD,       14'h3FFF, 4'hF,  5'd0,  1'b1,
          '{14'd9999, 4'd12, 5'd0,  5'd31, 3'd2, 3'd0, 3'd0, 1'b0}},
        '{CMD_NEXT_MONTH, 14'd0,    4'd0,  5'd0,  1'b1,
          '{14'd9999, 4'd12, 5'd0,  5'd31, 3'd2, 3'd0, 3'd0, 1'b0}},
        '{CMD_PREV_MONTH, 14'd0,    4'd0,  5'd0,  1'b1,
          '{14'd9999, 4'd12, 5'd0,  5'd31, 3'd2, 3'd0, 3'd0, 1'b0}},
        '{CMD_NEXT_DAY,   14'd0,    4'd0,  5'd0,  1'b0, '0},
        '{CMD_LOAD,       14'd2024, 4'd2,  5'd31, 1'b0, '0},
        '{CMD_NEXT_DAY,   14'd0,    4'd0,  5'd0,  1'b0, '0},
        '{CMD_LOAD,       14'd2024, 4'd2,  5'd28, 1'b0, '0},
        '{CMD_NEXT_DAY,   14'd0,    4'd0,  5'd0,  1'b0, '0},
        '{CMD_NEXT_DAY,   14'd0,    4'd0,  5'd0,  1'b0, '0},
        '{CMD_LOAD,       14'd2023, 4'd12, 5'd31, 1'b0, '0},
        '{CMD_NEXT_DAY,   14'd0,    4'd0,  5'd0,  1'b0, '0},
        '{CMD_LOAD,       14'd2026, 4'd1,  5'd1,  1'b0, '0},
        '{CMD_NEXT_MONTH, 14'd0,    4'd0,  5'd0,  1'b0, '0},
        '{CMD_LOAD,       14'd2026, 4'd3,  5'd31, 1'b0, '0},
        '{CMD_NEXT_MONTH, 14'd0,    4'd0,  5'd0,  1'b0, '0},
        '{CMD_LOAD,       14'd2026, 4'd3,  5'd31, 1'b0, '0},
        '{CMD_PREV_MONTH, 14'd0,    4'd0,  5'd0,  1'b0, '0},
        '{CMD_LOAD,       14'd2025, 4'd12, 5'd1,  1'b0, '0},
        '{CMD_PREV_MONTH, 14'd0,    4'd0,  5'd0,  1'b0, '0}
    };

    calendar_date_navigator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .cmd           (cmd),
        .load_year     (load_year),
        .load_month    (load_month),
        .load_day      (load_day),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .year          (year),
        .month         (month),
        .day           (day),
        .days_in_month (days_in_month),
        .first_weekday (first_weekday),
        .grid_row      (grid_row),
        .grid_col      (grid_col),
        .day_valid     (day_valid)
    );

    always #6 clk = ~clk;

    function automatic bit leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_days(int y, int m);
        if (m == 2)
            return leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // 0 = Monday
    function automatic int first_dow(int y, int m);
        if (m < 3)
        begin
            m += 12;
            y -= 1;
        end
        return (1 + 2 * m + (3 * (m + 1)) / 5 + y + y / 4 - y / 100 + y / 400) % 7;
    endfunction

    function automatic int grid_day(int p, int fw, int n);
        if (p < fw || p - fw >= n)
            return 0;
        return p - fw + 1;
    endfunction

    function automatic void set_cal_month(int y, int m);
        cal_y   = y;
        cal_m   = m;
        cal_fw  = first_dow(y, m);
        cal_len = month_days(y, m);
    endfunction

    function automatic cal_result_t predict_date(cmd_t c, int ly, int lm, int ld);
        cal_result_t r;
        int          y;
        int          m;
        int          p;
        int          fw;
        int          n;
        int          d;
        int          k;
        bit          ok;
        ok = (cal_d >= 1) && (cal_d <= cal_len);
        y  = cal_y;
        case (c)
            CMD_LOAD:
            begin
                if (ly < MIN_YEAR) ly = MIN_YEAR;
                if (ly > MAX_YEAR) ly = MAX_YEAR;
                if (lm < JAN) lm = JAN;
                if (lm > DEC) lm = DEC;
                set_cal_month(ly, lm);
                cal_d = ld;
            end
            CMD_NEXT_DAY:
            begin
                if (cal_d != cal_len)
                    cal_d = (cal_d + 1) % 32;
                else if (cal_m < DEC)
                begin
                    set_cal_month(cal_y, cal_m + 1);
                    cal_d = 1;
                end
                else if (cal_y < MAX_YEAR)
                begin
                    set_cal_month(cal_y + 1, JAN);
                    cal_d = 1;
                end
            end
            CMD_NEXT_MONTH:
            begin
                m = cal_m + 1;
                if (m > DEC)
                begin
                    if (y >= MAX_YEAR) ok = 1'b0;
                    m = JAN;
                    y = y + 1;
                end
                if (ok)
                begin
                    p  = cal_fw + cal_d - 1;
                    fw = first_dow(y, m);
                    n  = month_days(y, m);
                    if (p < fw)
                        d = 1;
                    else if (p - fw >= n)
                        d = n;
                    else
                        d = p - fw + 1;
                    set_cal_month(y, m);
                    cal_d = d;
                end
            end
            default:
            begin
                m = cal_m - 1;
                if (m == 0)
                begin
                    if (y <= MIN_YEAR) ok = 1'b0;
                    m = DEC;
                    y = y - 1;
                end
                if (ok)
                begin
                    p  = cal_fw + cal_d - 1;
                    fw = first_dow(y, m);
                    n  = month_days(y, m);
                    d  = grid_day(p, fw, n);
                    // leftward in the row, then the row above from its start
                    for (k = p % 7 - 1; k >= 0 && d == 0; k--)
                        d = grid_day((p / 7) * 7 + k, fw, n);
                    if (p / 7 > 0)
                        for (k = 0; k < 7 && d == 0; k++)
                            d = grid_day((p / 7 - 1) * 7 + k, fw, n);
                    if (d == 0)
                        d = n;
                    set_cal_month(y, m);
                    cal_d = d;
                end
            end
        endcase
        r.year  = 14'(cal_y);
        r.month = 4'(cal_m);
        r.day   = 5'(cal_d);
        r.len   = 5'(cal_len);
        r.fw    = 3'(cal_fw);
        r.valid = (cal_d >= 1) && (cal_d <= cal_len);
        p       = cal_fw + cal_d - 1;
        r.row   = r.valid ? 3'(p / 7) : 3'd0;
        r.col   = r.valid ? 3'(p % 7) : 3'd0;
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    task automatic issue_word(cmd_t c, logic [13:0] ly, logic [3:0] lm, logic [4:0] ld,
                              logic typed, cal_result_t want, int gap);
        cal_result_t pred;
        cmd_valid  <= 1'b1;
        cmd        <= c;
        load_year  <= ly;
        load_month <= lm;
        load_day   <= ld;
        do
            @(posedge clk);
        while (cmd_stall);
        pred = predict_date(c, int'(ly), int'(lm), int'(ld));
        expected_dates.push_back(typed ? want : pred);
        words_sent++;
        cmd_counts[c]++;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        cmd_valid <= 1'b0;
        while (expected_dates.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        cal_result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_dates.size() == 0)
            begin
                $error("result word with no command pending");
                errors++;
            end
            else
            begin
                want = expected_dates.pop_front();
                check_field("year", 16'(want.year), 16'(year));
                check_field("month", 16'(want.month), 16'(month));
                check_field("day", 16'(want.day), 16'(day));
                check_field("days_in_month", 16'(want.len), 16'(days_in_month));
                check_field("first_weekday", 16'(want.fw), 16'(first_weekday));
                check_field("grid_row", 16'(want.row), 16'(grid_row));
                check_field("grid_col", 16'(want.col), 16'(grid_col));
                check_field("day_valid", 16'(want.valid), 16'(day_valid));
                dates_checked++;
            end
        end
    end

    initial
    begin : res_stall_gen
        int n;
        int holds_done;
        holds_done = 0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done++;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                res_stall <= 1'b0;
            end
            else if (!no_idle)
            begin
                n = idle_len();
                if (n > 0)
                begin
                    res_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    res_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int   i;
        int   r;
        int   y;
        int   m;
        int   d;
        int   gap;
        int   burst_left;
        cmd_t c;
        rst_n      <= 1'b0;
        cmd_valid  <= 1'b0;
        cmd        <= CMD_LOAD;
        load_year  <= '0;
        load_month <= '0;
        load_day   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
            issue_word(dir_rows[i].cmd, dir_rows[i].ly, dir_rows[i].lm, dir_rows[i].ld,
                       dir_rows[i].typed, dir_rows[i].res, idle_len());
        wait_drain();

        burst_left = 0;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = (i % 150) >= 120;
            // long result hold-off while commands keep coming back to back
            if (i == 200)
            begin
                hold_requests++;
                burst_left = 24;
            end
            if (i == 450)
                wait_drain();
            r = $urandom_range(0, 99);
            if (r < 15)      c = CMD_LOAD;
            else if (r < 50) c = CMD_NEXT_DAY;
            else if (r < 75) c = CMD_NEXT_MONTH;
            else             c = CMD_PREV_MONTH;
            r = $urandom_range(0, 9);
            if (c != CMD_LOAD || r == 0)
            begin
                y = $urandom_range(0, 16383);
                m = $urandom_range(0, 15);
                d = $urandom_range(0, 31);
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0:       y = $urandom_range(1, 3);
                    1:       y = $urandom_range(9997, 9999);
                    2:       y = 100 * $urandom_range(16, 24);
                    default: y = $urandom_range(1, 9999);
                endcase
                m = $urandom_range(1, 12);
                d = (r == 1) ? $urandom_range(0, 31) : $urandom_range(1, month_days(y, m));
            end
            gap = (no_idle || burst_left > 0) ? 0 : idle_len();
            if (burst_left > 0)
                burst_left--;
            issue_word(c, 14'(y), 4'(m), 5'(d), 1'b0, '0, gap);
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_dates.size() != 0)
        begin
            $error("%0d result words never arrived", expected_dates.size());
            errors++;
        end
        $display("Sent %0d command words: %0d loads, %0d day steps, %0d next/%0d prev month.",
                 words_sent, cmd_counts[CMD_LOAD], cmd_counts[CMD_NEXT_DAY],
                 cmd_counts[CMD_NEXT_MONTH], cmd_counts[CMD_PREV_MONTH]);
        $display("Checked %0d result words under random idle and one long result hold-off.",
                 dates_checked);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
